// ===== hw/rtl/wfpd_pkg.sv =====
// Package for the wall-following PD steering block: types, register codes and constants.
`default_nettype none

package wfpd_pkg;

    // Defaults for the top-level parameters
    localparam int ADC_BITS_DEF       = 10;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Field widths
    localparam int RAW_W    = 10;
    localparam int SCALE_W  = 12;
    localparam int LEVEL_W  = 14;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Q8.8 PD gains
    localparam int PD_FRAC_BITS = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LEFT_SCALE  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_RIGHT_SCALE = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_LEFT_THR    = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_RIGHT_THR   = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_NOMINAL     = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_PROP_GAIN   = t_cfg_idx'(5);
    localparam t_cfg_idx CFG_DERIV_GAIN  = t_cfg_idx'(6);

    // Request actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [RAW_W-1:0] left_raw;
        logic [RAW_W-1:0] right_raw;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0]      left_level;
        logic [LEVEL_W-1:0]      right_level;
        logic                    left_wall;
        logic                    right_wall;
        logic signed [ERR_W-1:0] track_error;
        logic signed [ERR_W-1:0] steer_adjust;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_LVL_R,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_D,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/wall_follow_pd_steering.sv =====
// Wall-following PD steering: sensor scaling, wall detect, track error and PD adjust.
// A sensor request steps through MUL_L, MUL_R, LVL_R, ERR, MUL_P, MUL_D and DONE; a history
// reset goes straight to DONE. A new request is taken only back in IDLE, and the
//   pace is set by one shared 17x18 signed multiplier used four times per sample.
// A finished result sits in an output register, so the next request can be taken
//   while it waits. Reset (synchronous, active low) clears the sequencer, the output
//   valid and the error history, and loads the register defaults.
`default_nettype none

module wall_follow_pd_steering #(
    parameter int ADC_BITS       = wfpd_pkg::ADC_BITS_DEF,
    parameter int GAIN_FRAC_BITS = wfpd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration writes
    input  wire                               i_cfg_we,
    input  wfpd_pkg::t_cfg_idx                i_cfg_idx,
    input  wire  [wfpd_pkg::CFG_W-1:0]        i_cfg_data,
    // request channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wfpd_pkg::t_in                     i_in_data,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output wfpd_pkg::t_out                    o_out_data
);

    localparam int RAW_W   = wfpd_pkg::RAW_W;
    localparam int LEVEL_W = wfpd_pkg::LEVEL_W;
    localparam int ERR_W   = wfpd_pkg::ERR_W;
    localparam int GAIN_W  = wfpd_pkg::GAIN_W;
    localparam int SCALE_W = wfpd_pkg::SCALE_W;

    // Multiplier operands: A holds a 12-bit scale or a 16-bit gain, B a raw
    // reading, the error or the 17-bit error difference.
    localparam int MA_W  = GAIN_W + 1;
    localparam int MB_W  = ERR_W + 2;
    localparam int PRD_W = MA_W + MB_W;
    localparam int SUM_W = PRD_W + 1;

    // Raw bits above the converter width are masked off
    localparam int MASK_BITS = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RAW_MASK = {RAW_W{1'b1}} >> (RAW_W - MASK_BITS);

    localparam logic signed [SUM_W-1:0] ADJ_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] ADJ_MIN = -SUM_W'(32768);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        [SCALE_W-1:0] r_left_scale, r_right_scale;
    logic        [LEVEL_W-1:0] r_left_thr, r_right_thr, r_nominal;
    logic signed [GAIN_W-1:0]  r_prop_gain, r_deriv_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_scale  <= wfpd_pkg::SCALE_RST;
            r_right_scale <= wfpd_pkg::SCALE_RST;
            r_left_thr    <= '0;
            r_right_thr   <= '0;
            r_nominal     <= '0;
            r_prop_gain   <= '0;
            r_deriv_gain  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wfpd_pkg::CFG_LEFT_SCALE:  r_left_scale  <= i_cfg_data[SCALE_W-1:0];
                wfpd_pkg::CFG_RIGHT_SCALE: r_right_scale <= i_cfg_data[SCALE_W-1:0];
                wfpd_pkg::CFG_LEFT_THR:    r_left_thr    <= i_cfg_data[LEVEL_W-1:0];
                wfpd_pkg::CFG_RIGHT_THR:   r_right_thr   <= i_cfg_data[LEVEL_W-1:0];
                wfpd_pkg::CFG_NOMINAL:     r_nominal     <= i_cfg_data[LEVEL_W-1:0];
                wfpd_pkg::CFG_PROP_GAIN:   r_prop_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                wfpd_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= $signed(i_cfg_data[GAIN_W-1:0]);
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------
    wfpd_pkg::t_state r_state, n_state;

    wfpd_pkg::t_in            r_req;      // captured request
    logic signed [PRD_W-1:0]  r_prod;     // shared multiplier output
    logic signed [PRD_W-1:0]  r_acc;      // proportional term
    logic [LEVEL_W-1:0]       r_ll, r_rl; // scaled levels
    logic                     r_lw, r_rw; // wall flags
    logic signed [ERR_W-1:0]  r_err;      // this step's track error
    logic signed [ERR_W-1:0]  r_last_err; // previous error (D term)
    logic signed [ERR_W-1:0]  r_held_err; // error restored by a history reset
    logic                     r_out_valid;
    wfpd_pkg::t_out           r_out;

    logic                     in_take;
    logic                     out_load;

    // Shared multiplier
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PRD_W-1:0]  mul_p;
    logic signed [ERR_W:0]    err_diff;

    // Level saturation from the multiplier register
    logic signed [PRD_W-1:0]  lvl_shift;
    logic [LEVEL_W-1:0]       lvl_sat;

    // Track error
    logic signed [LEVEL_W:0]  el, er;
    logic signed [ERR_W:0]    err_wide;

    // PD sum, floor shift and clamp
    logic signed [SUM_W-1:0]  pd_sum, pd_shift;
    logic signed [ERR_W-1:0]  pd_sat;

    // Next state and stall
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        in_take    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            wfpd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
                if (i_in_valid) begin
                    n_state = (i_in_data.action == wfpd_pkg::ACT_RESET)
                              ? wfpd_pkg::ST_DONE : wfpd_pkg::ST_MUL_L;
                end
            end
            wfpd_pkg::ST_MUL_L: n_state = wfpd_pkg::ST_MUL_R;
            wfpd_pkg::ST_MUL_R: n_state = wfpd_pkg::ST_LVL_R;
            wfpd_pkg::ST_LVL_R: n_state = wfpd_pkg::ST_ERR;
            wfpd_pkg::ST_ERR:   n_state = wfpd_pkg::ST_MUL_P;
            wfpd_pkg::ST_MUL_P: n_state = wfpd_pkg::ST_MUL_D;
            wfpd_pkg::ST_MUL_D: n_state = wfpd_pkg::ST_DONE;
            wfpd_pkg::ST_DONE: begin
                // wait for the output register to free up
                out_load = !r_out_valid || !i_out_stall;
                if (out_load) begin
                    n_state = wfpd_pkg::ST_IDLE;
                end
            end
            default: n_state = wfpd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfpd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand select for the shared multiplier
    assign err_diff = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_last_err);

    always_comb begin
        unique case (r_state)
            wfpd_pkg::ST_MUL_L: begin
                mul_a = $signed(MA_W'(r_left_scale));
                mul_b = $signed(MB_W'(r_req.left_raw & RAW_MASK));
            end
            wfpd_pkg::ST_MUL_R: begin
                mul_a = $signed(MA_W'(r_right_scale));
                mul_b = $signed(MB_W'(r_req.right_raw & RAW_MASK));
            end
            wfpd_pkg::ST_MUL_P: begin
                mul_a = MA_W'(r_prop_gain);
                mul_b = MB_W'(r_err);
            end
            wfpd_pkg::ST_MUL_D: begin
                mul_a = MA_W'(r_deriv_gain);
                mul_b = MB_W'(err_diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // (raw * scale) >> GAIN_FRAC_BITS, clamped to the level range
    assign lvl_shift = r_prod >>> GAIN_FRAC_BITS;
    assign lvl_sat   = (lvl_shift > $signed(PRD_W'(wfpd_pkg::LEVEL_MAX)))
                       ? wfpd_pkg::LEVEL_MAX : lvl_shift[LEVEL_W-1:0];

    // Error from the walls seen; always fits 16 bits signed
    assign el = $signed({1'b0, r_ll}) - $signed({1'b0, r_nominal});
    assign er = $signed({1'b0, r_rl}) - $signed({1'b0, r_nominal});

    always_comb begin
        case ({r_lw, r_rw})
            2'b11:   err_wide = (ERR_W+1)'(el) - (ERR_W+1)'(er);
            2'b10:   err_wide = (ERR_W+1)'(el) <<< 1;
            2'b01:   err_wide = -((ERR_W+1)'(er) <<< 1);
            default: err_wide = '0;
        endcase
    end

    // P + D, shifted right with floor, clamped to 16 bits
    assign pd_sum   = SUM_W'(r_acc) + SUM_W'(r_prod);
    assign pd_shift = pd_sum >>> wfpd_pkg::PD_FRAC_BITS;
    always_comb begin
        if (pd_shift > ADJ_MAX) begin
            pd_sat = ERR_W'(ADJ_MAX);
        end else if (pd_shift < ADJ_MIN) begin
            pd_sat = ERR_W'(ADJ_MIN);
        end else begin
            pd_sat = pd_shift[ERR_W-1:0];
        end
    end

    // Datapath (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in_data;
        end
        unique case (r_state)
            wfpd_pkg::ST_MUL_L: r_prod <= mul_p;
            wfpd_pkg::ST_MUL_R: begin
                r_ll   <= lvl_sat;
                r_lw   <= lvl_sat > r_left_thr;
                r_prod <= mul_p;
            end
            wfpd_pkg::ST_LVL_R: begin
                r_rl <= lvl_sat;
                r_rw <= lvl_sat > r_right_thr;
            end
            wfpd_pkg::ST_ERR:   r_err <= err_wide[ERR_W-1:0];
            wfpd_pkg::ST_MUL_P: r_prod <= mul_p;
            wfpd_pkg::ST_MUL_D: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            default: ;
        endcase
        if (out_load) begin
            if (r_req.action == wfpd_pkg::ACT_RESET) begin
                r_out.left_level   <= '0;
                r_out.right_level  <= '0;
                r_out.left_wall    <= 1'b0;
                r_out.right_wall   <= 1'b0;
                r_out.track_error  <= r_held_err;
                r_out.steer_adjust <= '0;
            end else begin
                r_out.left_level   <= r_ll;
                r_out.right_level  <= r_rl;
                r_out.left_wall    <= r_lw;
                r_out.right_wall   <= r_rw;
                r_out.track_error  <= r_err;
                r_out.steer_adjust <= pd_sat;
            end
        end
    end

    // Error history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_held_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                if (r_req.action == wfpd_pkg::ACT_RESET) begin
                    r_last_err <= r_held_err;
                end else begin
                    r_last_err <= r_err;
                    r_held_err <= r_err;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/wfpd_chk.sv =====
// Port-level checker for the wall-following PD steering block, bound to the top level.
`default_nettype none

module wfpd_chk (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_stall,
    input wire            o_out_valid,
    input wire            i_out_stall,
    input wfpd_pkg::t_out o_out_data
);

    // a taken request keeps the block busy for at least the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken but block not busy");

    // a new result only appears at the end of work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // reset empties the output and frees the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind wall_follow_pd_steering wfpd_chk u_wfpd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
